FILE: hdl/eap_sim_attribute_deframer_unit_defines.svh
// assertion macros shared by the deframer modules
`ifndef EAP_SIM_ATTRIBUTE_DEFRAMER_UNIT_DEFINES_SVH
`define EAP_SIM_ATTRIBUTE_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EAPSA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define EAPSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/eapsa_pkg.sv
package eapsa_pkg;

    // largest attribute, header included, whose bytes are emitted
    localparam int MAX_ATTR_BYTES = 256;
    localparam int BIA_W          = 10;
    localparam logic [BIA_W-1:0] MAX_LIM = BIA_W'(MAX_ATTR_BYTES);

    localparam logic [2:0] BODY_MIN = 3'd5;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_SUBTYPE,
        PH_RES1,
        PH_RES2,
        PH_TYPE,
        PH_LEN,
        PH_VALUE,
        PH_ERR
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SUBTYPE = 2'd0,
        KIND_VALUE   = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_HDR_CUT  = 3'd2,
        ST_OVERRUN  = 3'd3,
        ST_ZERO_LEN = 3'd4
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  attr_type;
        logic [15:0] attr_index;
        logic [7:0]  out_byte;
        logic        value_end;
        t_status     status;
    } t_result;

    // up to two results caused by one input item, in output order
    typedef struct packed {
        logic    v0;
        t_result r0;
        logic    v1;
        t_result r1;
    } t_push;

endpackage

FILE: hdl/eapsa_parser.sv
`include "eap_sim_attribute_deframer_unit_defines.svh"

module eapsa_parser
    import eapsa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_fin,
    output t_push      o_push
);

    t_phase            r_phase,    n_phase;
    logic [2:0]        r_body_cnt, n_body_cnt;
    logic [7:0]        r_type,     n_type;
    logic [7:0]        r_units,    n_units;
    logic [BIA_W-1:0]  r_bia,      n_bia;
    logic [15:0]       r_attr_cnt, n_attr_cnt;
    t_status           r_err,      n_err;

    logic [BIA_W-1:0]  full;
    logic [BIA_W-1:0]  lim;
    logic [BIA_W-1:0]  bia_inc;
    t_status           fin_st;
    t_push             push;

    assign full    = {r_units, 2'b00};
    assign lim     = (full > MAX_LIM) ? MAX_LIM : full;
    assign bia_inc = r_bia + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_body_cnt = (r_body_cnt < BODY_MIN) ? r_body_cnt + 3'd1 : r_body_cnt;
        n_type     = r_type;
        n_units    = r_units;
        n_bia      = r_bia;
        n_attr_cnt = r_attr_cnt;
        n_err      = r_err;
        push       = '0;
        fin_st     = ST_OK;

        if (r_err == ST_OK) begin
            case (r_phase)
                PH_SUBTYPE: begin
                    push.v0          = 1'b1;
                    push.r0.kind     = KIND_SUBTYPE;
                    push.r0.out_byte = i_byte;
                    n_phase          = PH_RES1;
                end
                PH_RES1: n_phase = PH_RES2;
                PH_RES2: n_phase = PH_TYPE;
                PH_TYPE: begin
                    n_type  = i_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_units = i_byte;
                    if (i_byte == 8'd0) begin
                        n_err   = ST_ZERO_LEN;
                        n_phase = PH_ERR;
                    end else begin
                        n_bia   = BIA_W'(2);
                        n_phase = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (r_bia < lim) begin
                        push.v0            = 1'b1;
                        push.r0.kind       = KIND_VALUE;
                        push.r0.attr_type  = r_type;
                        push.r0.attr_index = r_attr_cnt;
                        push.r0.out_byte   = i_byte;
                        push.r0.value_end  = (bia_inc == lim);
                    end
                    n_bia = bia_inc;
                    if (bia_inc >= full) begin
                        n_attr_cnt = r_attr_cnt + 16'd1;
                        n_bia      = '0;
                        n_phase    = PH_TYPE;
                    end
                end
                default: ;
            endcase
        end

        if (i_fin) begin
            if (n_body_cnt < BODY_MIN) begin
                fin_st = ST_SHORT;
            end else if (n_err != ST_OK) begin
                fin_st = n_err;
            end else if (n_phase == PH_TYPE) begin
                fin_st = ST_OK;
            end else if (n_phase == PH_LEN) begin
                fin_st = ST_HDR_CUT;
            end else begin
                fin_st = ST_OVERRUN;
            end
            push.v1            = 1'b1;
            push.r1.kind       = KIND_STATUS;
            push.r1.attr_index = n_attr_cnt;
            push.r1.status     = fin_st;
            // body done: back to the start state
            n_phase    = PH_SUBTYPE;
            n_body_cnt = '0;
            n_type     = '0;
            n_units    = '0;
            n_bia      = '0;
            n_attr_cnt = '0;
            n_err      = ST_OK;
        end
    end

    assign o_push = i_fire ? push : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SUBTYPE;
            r_body_cnt <= '0;
            r_type     <= '0;
            r_units    <= '0;
            r_bia      <= '0;
            r_attr_cnt <= '0;
            r_err      <= ST_OK;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_body_cnt <= n_body_cnt;
            r_type     <= n_type;
            r_units    <= n_units;
            r_bia      <= n_bia;
            r_attr_cnt <= n_attr_cnt;
            r_err      <= n_err;
        end
    end

    `EAPSA_ASSERT_IMPLY(a_body_sat, 1'b1, r_body_cnt <= BODY_MIN, "body count past saturation")
    `EAPSA_ASSERT_IMPLY(a_err_phase, r_err != ST_OK, r_phase == PH_ERR, "error without error phase")
    `EAPSA_ASSERT_NEXT(a_fin_clear, i_fire && i_fin, r_phase == PH_SUBTYPE && r_attr_cnt == 16'd0 && r_err == ST_OK, "state not cleared after final byte")

endmodule

FILE: hdl/eapsa_ofifo.sv
`include "eap_sim_attribute_deframer_unit_defines.svh"

module eapsa_ofifo
    import eapsa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_valid,
    output logic    o_room,
    output t_result o_head
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr,  n_wr;
    logic [FIFO_AW-1:0]   r_rd,  n_rd;
    logic [FIFO_CW-1:0]   r_cnt, n_cnt;

    logic                 w0, w1;
    t_result              d0;
    logic [FIFO_CW-1:0]   num;
    logic [FIFO_AW-1:0]   wr1;

    // a lone status result moves into the first slot
    assign w0  = i_push.v0 || i_push.v1;
    assign w1  = i_push.v0 && i_push.v1;
    assign d0  = i_push.v0 ? i_push.r0 : i_push.r1;
    assign num = FIFO_CW'(w0) + FIFO_CW'(w1);
    assign wr1 = r_wr + 1'b1;

    assign n_wr  = r_wr + FIFO_AW'(num);
    assign n_rd  = i_pop ? r_rd + 1'b1 : r_rd;
    assign n_cnt = r_cnt + num - FIFO_CW'(i_pop);

    always_ff @(posedge i_clk) begin
        if (w0) begin
            r_mem[r_wr] <= d0;
        end
        if (w1) begin
            r_mem[wr1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_head  = r_mem[r_rd];

    `EAPSA_ASSERT_IMPLY(a_cnt_max, 1'b1, r_cnt <= FIFO_CW'(FIFO_DEPTH), "result queue overflow")
    `EAPSA_ASSERT_IMPLY(a_push_room, w0, o_room, "push without room for two items")
    `EAPSA_ASSERT_NEXT(a_cnt_hold, !w0 && !i_pop, $stable(r_cnt), "count moved without push or pop")

endmodule

FILE: hdl/eap_sim_attribute_deframer_unit.sv
// eap-sim attribute deframer
//
// slave channel: one body byte per item, tdata = data byte, tlast = final byte
// of the body. master channel: one result per item. tuser = kind (subtype,
// attribute value byte, end status), tlast = last emitted value byte of an
// attribute, tdata = attr_type, attr_index, out_byte, status (low bit up).
//
// an accepted byte waits in the input register until the queue has room, is
// parsed there and its results (at most two: a subtype or value byte and, on
// the final byte, the end status) go into a four-entry result queue, so a
// byte passes the input register and the queue before its result handshake. a
// byte is taken every cycle while the queue holds two items or fewer, so the
// sustained rate is one byte per cycle; a final byte adds one more result.
//
// reset clears the parser to expect a subtype byte and empties the queue.
// when the receiver stalls the queue fills, the input register holds its
// byte and tready drops; no result is lost or repeated.
module eap_sim_attribute_deframer_unit
    import eapsa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic        i_s_axis_tlast,   // final_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // attr_type, attr_index, out_byte, status, zero fill
    output logic [1:0]  o_m_axis_tuser,   // kind
    output logic        o_m_axis_tlast    // value_end
);

    // input register
    logic       r_in_vld, n_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_fin;

    logic       load;
    logic       fire;
    logic       room;
    logic       pop;
    t_push      push;
    t_result    head;

    // parse when the queue can take two more items
    assign fire            = r_in_vld && room;
    assign o_s_axis_tready = !r_in_vld || fire;
    assign load            = i_s_axis_tvalid && o_s_axis_tready;
    assign n_in_vld        = load ? 1'b1 : (fire ? 1'b0 : r_in_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_fin  <= i_s_axis_tlast;
        end
    end

    eapsa_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_fin   (r_in_fin),
        .o_push  (push)
    );

    assign pop = o_m_axis_tvalid && i_m_axis_tready;

    eapsa_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .o_room  (room),
        .o_head  (head)
    );

    // pack result fields, first field lowest
    assign o_m_axis_tdata = {5'b0, head.status, head.out_byte, head.attr_index, head.attr_type};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.value_end;

endmodule
